// ===== design/skvt_pkg.sv =====
// Package for the sorted key/value table: operation, status and cell action codes.
// No dependencies.
package skvt_pkg;
  localparam logic [3:0] OP_PUT      = 4'd0;
  localparam logic [3:0] OP_GET      = 4'd1;
  localparam logic [3:0] OP_REM_KEY  = 4'd2;
  localparam logic [3:0] OP_REM_AT   = 4'd3;
  localparam logic [3:0] OP_REM_RNG  = 4'd4;
  localparam logic [3:0] OP_READ_AT  = 4'd5;
  localparam logic [3:0] OP_WRITE_AT = 4'd6;
  localparam logic [3:0] OP_FIND     = 4'd7;
  localparam logic [3:0] OP_CLEAR    = 4'd8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_POS   = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // per-cell action broadcast along the chain
  localparam logic [1:0] ACT_HOLD   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_WRITE  = 2'd3;

  typedef struct packed {
    logic [1:0] act;
  } cell_ctl_t;
endpackage

// ===== design/skvt_cell.sv =====
// One table entry: holds a key and value, compares them, and shifts with its neighbours.
// Depends on skvt_pkg.
module skvt_cell #(
  parameter int VW = 32,
  parameter int PW = 6
) (
  input  logic                  clk,
  input  skvt_pkg::cell_ctl_t   ctl,
  input  logic [PW:0]           idx,
  input  logic [PW:0]           tpos,
  input  logic signed [31:0]    in_key,
  input  logic [VW-1:0]         in_value,
  input  logic signed [31:0]    lo_key,
  input  logic [VW-1:0]         lo_value,
  input  logic signed [31:0]    hi_key,
  input  logic [VW-1:0]         hi_value,
  output logic signed [31:0]    key,
  output logic [VW-1:0]         value,
  output logic                  ge_key,
  output logic                  eq_value
);
  import skvt_pkg::*;

  assign ge_key = key >= in_key;
  assign eq_value = value == in_value;

  always_ff @(posedge clk) begin
    case (ctl.act)
      ACT_INSERT: begin
        if (idx == tpos) begin
          key <= in_key;
          value <= in_value;
        end else if (idx > tpos) begin
          key <= lo_key;
          value <= lo_value;
        end
      end
      ACT_REMOVE: begin
        if (idx >= tpos) begin
          key <= hi_key;
          value <= hi_value;
        end
      end
      ACT_WRITE: begin
        if (idx == tpos) value <= in_value;
      end
      default: begin
      end
    endcase
  end
endmodule

// ===== design/sorted_key_value_table.sv =====
// Top level: command port, operation control and the chain of table cells.
// Depends on skvt_pkg and skvt_cell.
//
//  channel  | handshake            | fields
//  command  | start / busy         | mode key value position batch_count
//  result   | done (one cycle)     | status result_position result_key result_value
//           |                      | removed_count entry_count
//
// A command is latched while idle; the evaluate state compares all cells,
// decodes and applies the shift or write; done marks the result. Removing a range
// shifts one place a cycle, clipped at the table's end, done on the last shift.
// Reset empties the table. busy is high while a command is at work; results
// cannot be stalled.
module sorted_key_value_table #(
  parameter int CAPACITY = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [3:0]              mode,
  input  logic signed [31:0]      key,
  input  logic [31:0]             value,
  input  logic [6:0]              position,
  input  logic [6:0]              batch_count,
  output logic                    done,
  output logic [2:0]              status,
  output logic [5:0]              result_position,
  output logic signed [31:0]      result_key,
  output logic [31:0]             result_value,
  output logic [6:0]              removed_count,
  output logic [6:0]              entry_count
);
  import skvt_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = PW + 1;
  localparam int VW = VALUE_WIDTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]             state, state_next;
  logic [3:0]             op;
  logic signed [31:0]     op_key;
  logic [VW-1:0]          op_value;
  logic [6:0]             op_pos;
  logic [6:0]             op_cnt;
  logic [CW-1:0]          fill;
  logic [CW-1:0]          tpos;
  logic [6:0]             left;
  cell_ctl_t              ctl;

  logic signed [31:0]     ck [CAPACITY];
  logic [VW-1:0]          cv [CAPACITY];
  logic [CAPACITY-1:0]    ge, eqv;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] lk, hk;
      logic [VW-1:0]      lv, hv;
      if (g == 0) begin : g_lo0
        assign lk = op_key;
        assign lv = op_value;
      end else begin : g_lo
        assign lk = ck[g-1];
        assign lv = cv[g-1];
      end
      if (g == CAPACITY - 1) begin : g_hiN
        assign hk = ck[g];
        assign hv = cv[g];
      end else begin : g_hi
        assign hk = ck[g+1];
        assign hv = cv[g+1];
      end
      skvt_cell #(.VW(VW), .PW(PW)) u_cell (
        .clk(clk), .ctl(ctl), .idx(CW'(g)), .tpos(tpos),
        .in_key(op_key), .in_value(op_value),
        .lo_key(lk), .lo_value(lv), .hi_key(hk), .hi_value(hv),
        .key(ck[g]), .value(cv[g]), .ge_key(ge[g]), .eq_value(eqv[g])
      );
    end
  endgenerate

  // lower bound and first value match via priority over valid cells
  logic [CW-1:0] lb, fv;
  logic          fv_hit;
  always_comb begin
    lb = fill;
    fv = '0;
    fv_hit = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (CW'(i) < fill && ge[i]) lb = CW'(i);
      if (CW'(i) < fill && eqv[i]) begin
        fv = CW'(i);
        fv_hit = 1'b1;
      end
    end
  end

  logic signed [31:0] lb_key;
  logic [VW-1:0]      lb_val, pos_val;
  logic signed [31:0] pos_key;
  logic               hit, pos_ok;
  always_comb begin
    lb_key = '0;
    lb_val = '0;
    pos_key = '0;
    pos_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lb[PW-1:0] == PW'(i)) begin
        lb_key = ck[i];
        lb_val = cv[i];
      end
      if (op_pos == 7'(i)) begin
        pos_key = ck[i];
        pos_val = cv[i];
      end
    end
  end
  assign hit = (lb < fill) && (lb_key == op_key);
  assign pos_ok = {{(CW > 7 ? CW - 7 : 0){1'b0}}, op_pos} < {{(7 > CW ? 7 - CW : 0){1'b0}}, fill};

  logic [CW-1:0] avail;
  assign avail = fill - CW'(op_pos);

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_EVAL;
      S_EVAL: begin
        if (op == OP_REM_RNG && pos_ok && op_cnt != 7'd0) state_next = S_SHIFT;
        else state_next = S_IDLE;
      end
      S_SHIFT: if (left == 7'd1) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.act = ACT_HOLD;
    tpos = lb;
    case (state)
      S_EVAL: begin
        case (op)
          OP_PUT: begin
            if (hit) ctl.act = ACT_WRITE;
            else if (fill < CW'(CAPACITY)) ctl.act = ACT_INSERT;
          end
          OP_REM_KEY: if (hit) ctl.act = ACT_REMOVE;
          OP_REM_AT: begin
            tpos = CW'(op_pos);
            if (pos_ok) ctl.act = ACT_REMOVE;
          end
          OP_WRITE_AT: begin
            tpos = CW'(op_pos);
            if (pos_ok) ctl.act = ACT_WRITE;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        tpos = CW'(op_pos);
        ctl.act = ACT_REMOVE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (state == S_IDLE && start) begin
        op <= mode;
        op_key <= key;
        op_value <= VW'(value);
        op_pos <= position;
        op_cnt <= batch_count;
      end
      if (state == S_EVAL) begin
        status <= ST_OK;
        result_position <= '0;
        result_key <= '0;
        result_value <= '0;
        removed_count <= '0;
        done <= 1'b1;
        case (op)
          OP_PUT: begin
            if (hit) result_position <= 6'(lb);
            else if (fill < CW'(CAPACITY)) begin
              result_position <= 6'(lb);
              fill <= fill + 1'b1;
            end else status <= ST_FULL;
          end
          OP_GET, OP_REM_KEY: begin
            if (!hit) status <= ST_NOT_FOUND;
            else begin
              result_position <= 6'(lb);
              result_value <= 32'(lb_val);
              if (op == OP_GET) result_key <= lb_key;
              else begin
                removed_count <= 7'd1;
                fill <= fill - 1'b1;
              end
            end
          end
          OP_REM_AT, OP_READ_AT, OP_WRITE_AT: begin
            if (!pos_ok) status <= ST_BAD_POS;
            else begin
              result_position <= 6'(op_pos);
              if (op == OP_REM_AT) begin
                result_value <= 32'(pos_val);
                removed_count <= 7'd1;
                fill <= fill - 1'b1;
              end else if (op == OP_READ_AT) begin
                result_key <= pos_key;
                result_value <= 32'(pos_val);
              end
            end
          end
          OP_REM_RNG: begin
            if (!pos_ok) status <= ST_BAD_POS;
            else if (op_cnt == 7'd0) status <= ST_BAD_COUNT;
            else begin
              done <= 1'b0;
              result_position <= 6'(op_pos);
              if (CW'(op_cnt) > avail || op_cnt > 7'(avail)) left <= 7'(avail);
              else left <= op_cnt;
              removed_count <= (CW'(op_cnt) > avail || op_cnt > 7'(avail)) ?
                               7'(avail) : op_cnt;
            end
          end
          OP_FIND: begin
            if (fv_hit) result_position <= 6'(fv);
            else status <= ST_NOT_FOUND;
          end
          OP_CLEAR: begin
            removed_count <= 7'(fill);
            fill <= '0;
          end
          default: begin
          end
        endcase
      end
      if (state == S_SHIFT) begin
        left <= left - 7'd1;
        fill <= fill - 1'b1;
        if (left == 7'd1) done <= 1'b1;
      end
    end
  end

  assign entry_count = 7'(fill);
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for sorted_key_value_table: directed and random command streams
// checked beat by beat against an in-bench model of the ordered table.
// Depends on skvt_pkg and the sorted_key_value_table RTL.
module tb;
  import skvt_pkg::*;

  localparam int CAP = 64;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  rpos;
    logic [31:0] rkey;
    logic [31:0] rval;
    logic [6:0]  removed;
    logic [6:0]  entries;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [3:0] mode = '0;
  logic signed [31:0] key = '0;
  logic [31:0] value = '0;
  logic [6:0] position = '0;
  logic [6:0] batch_count = '0;
  logic done;
  logic [2:0] status;
  logic [5:0] result_position;
  logic signed [31:0] result_key;
  logic [31:0] result_value;
  logic [6:0] removed_count;
  logic [6:0] entry_count;

  sorted_key_value_table u_top (
    .clk, .rst, .start, .busy, .mode, .key, .value, .position, .batch_count,
    .done, .status, .result_position, .result_key, .result_value,
    .removed_count, .entry_count
  );

  always #1 clk = ~clk;

  logic signed [31:0] tbl_key [CAP];
  logic [31:0] tbl_val [CAP];
  int fill;
  table_result_t pending_results [$];
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int idle_cycles = 0;
  bit allow_gaps = 1'b1;
  int key_pool [$];

  function automatic int lower_pos(logic signed [31:0] k);
    int i;
    for (i = 0; i < fill; i++)
      if (tbl_key[i] >= k) break;
    return i;
  endfunction

  function automatic void close_gap(int p, int n);
    for (int i = p; i + n < fill; i++) begin
      tbl_key[i] = tbl_key[i + n];
      tbl_val[i] = tbl_val[i + n];
    end
    fill -= n;
  endfunction

  function automatic table_result_t apply_command(logic [3:0] m, logic signed [31:0] k,
                                                  logic [31:0] v, int p, int c);
    table_result_t r;
    int lb;
    r = '0;
    case (m)
      OP_PUT: begin
        lb = lower_pos(k);
        if (lb < fill && tbl_key[lb] == k) begin
          tbl_val[lb] = v;
          r.rpos = 6'(lb);
        end else if (fill >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int i = fill; i > lb; i--) begin
            tbl_key[i] = tbl_key[i - 1];
            tbl_val[i] = tbl_val[i - 1];
          end
          tbl_key[lb] = k;
          tbl_val[lb] = v;
          fill++;
          r.rpos = 6'(lb);
        end
      end
      OP_GET, OP_REM_KEY: begin
        lb = lower_pos(k);
        if (!(lb < fill && tbl_key[lb] == k)) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.rpos = 6'(lb);
          r.rval = tbl_val[lb];
          if (m == OP_GET) r.rkey = tbl_key[lb];
          else begin
            close_gap(lb, 1);
            r.removed = 7'd1;
          end
        end
      end
      OP_REM_AT, OP_READ_AT, OP_WRITE_AT: begin
        if (p >= fill) r.status = ST_BAD_POS;
        else begin
          r.rpos = 6'(p);
          if (m == OP_REM_AT) begin
            r.rval = tbl_val[p];
            close_gap(p, 1);
            r.removed = 7'd1;
          end else if (m == OP_READ_AT) begin
            r.rkey = tbl_key[p];
            r.rval = tbl_val[p];
          end else tbl_val[p] = v;
        end
      end
      OP_REM_RNG: begin
        if (p >= fill) r.status = ST_BAD_POS;
        else if (c == 0) r.status = ST_BAD_COUNT;
        else begin
          if (c > fill - p) c = fill - p;
          close_gap(p, c);
          r.removed = 7'(c);
          r.rpos = 6'(p);
        end
      end
      OP_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < fill; i++)
          if (tbl_val[i] == v) begin
            r.status = ST_OK;
            r.rpos = 6'(i);
            break;
          end
      end
      OP_CLEAR: begin
        r.removed = 7'(fill);
        fill = 0;
      end
      default: ;
    endcase
    r.entries = 7'(fill);
    return r;
  endfunction

  task automatic send_beat(logic [3:0] m, logic signed [31:0] k, logic [31:0] v,
                           logic [6:0] p, logic [6:0] c);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start <= 1'b1;
    mode <= m;
    key <= k;
    value <= v;
    position <= p;
    batch_count <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_command(m, k, v, p, c));
    beats_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    table_result_t got, want;
    if (!rst && done) begin
      got = {status, result_position, result_key, result_value, removed_count, entry_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch beat %0d: exp st=%0d pos=%0d key=%h val=%h rm=%0d n=%0d",
                     beats_checked, want.status, want.rpos, want.rkey, want.rval,
                     want.removed, want.entries);
          if (mismatches <= 10)
            $display("                got st=%0d pos=%0d key=%h val=%h rm=%0d n=%0d",
                     got.status, got.rpos, got.rkey, got.rval, got.removed, got.entries);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog: no progress");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 2) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_value();
    if (fill > 0 && $urandom_range(0, 2) == 0) return tbl_val[$urandom_range(0, fill - 1)];
    return $urandom;
  endfunction

  task automatic test_directed();
    send_beat(OP_GET, 0, 0, 0, 0);
    send_beat(OP_REM_AT, 0, 0, 0, 1);
    send_beat(OP_REM_RNG, 0, 0, 0, 1);
    send_beat(OP_FIND, 0, 0, 0, 0);
    send_beat(OP_PUT, 32'sh7FFFFFFF, 32'hFFFFFFFF, 0, 0);
    send_beat(OP_PUT, 32'sh80000000, 32'h0, 0, 0);
    send_beat(OP_PUT, 0, 32'hA5A5A5A5, 0, 0);
    send_beat(OP_PUT, 0, 32'h5A5A5A5A, 0, 0);
    send_beat(OP_PUT, -1, 32'h1, 0, 0);
    send_beat(OP_GET, 32'sh80000000, 0, 0, 0);
    send_beat(OP_GET, 5, 0, 0, 0);
    send_beat(OP_READ_AT, 0, 0, 7'd3, 0);
    send_beat(OP_READ_AT, 0, 0, 7'd127, 0);
    send_beat(OP_WRITE_AT, 0, 32'hFFFFFFFF, 7'd1, 0);
    send_beat(OP_FIND, 0, 32'hFFFFFFFF, 0, 0);
    send_beat(OP_REM_RNG, 0, 0, 7'd1, 7'd0);
    send_beat(OP_REM_KEY, -1, 0, 0, 0);
    send_beat(OP_REM_KEY, -1, 0, 0, 0);
    send_beat(OP_REM_AT, 0, 0, 7'd0, 0);
    send_beat(OP_REM_RNG, 0, 0, 7'd0, 7'd127);
    send_beat(4'd9, 32'sh12345678, 32'h1, 7'h55, 7'h2A);
    send_beat(4'd15, 0, 0, 7'h2A, 7'h55);
    send_beat(OP_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < CAP; i++) send_beat(OP_PUT, (i * 7919) ^ 32'h8000_0000, i, 0, 0);
    send_beat(OP_PUT, 32'sh0000_0003, 32'hDEAD, 0, 0);
    send_beat(OP_PUT, 32'sh8000_0000, 32'hBEEF, 0, 0);
    send_beat(OP_READ_AT, 0, 0, 7'd63, 0);
    send_beat(OP_REM_RNG, 0, 0, 7'd60, 7'd10);
    send_beat(OP_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_random(int n);
    logic [3:0] m;
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i == n - 100) allow_gaps = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 35) m = OP_PUT;
      else if (pick < 45) m = OP_GET;
      else if (pick < 53) m = OP_REM_KEY;
      else if (pick < 60) m = OP_REM_AT;
      else if (pick < 64) m = OP_REM_RNG;
      else if (pick < 74) m = OP_READ_AT;
      else if (pick < 82) m = OP_WRITE_AT;
      else if (pick < 92) m = OP_FIND;
      else if (pick < 95) m = OP_CLEAR;
      else m = 4'($urandom_range(9, 15));
      if (m == OP_PUT && $urandom_range(0, 3) == 0) key_pool.push_back($urandom);
      if (key_pool.size() > 40) key_pool.delete(0);
      send_beat(m, pick_key(), pick_value(),
                7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                             : $urandom_range(0, fill > 0 ? fill : 0)),
                7'($urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                             : $urandom_range(0, 4)));
    end
  endtask

  initial begin
    fill = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random(510);
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d commands, %0d results checked: all nine operations,", beats_sent,
             beats_checked);
    $display("unused modes, full table, clipped ranges and error statuses");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
